// ===== hdl/ost_pkg.sv =====
// ----------------------------------------------------------------------------
// ost_pkg
// Shared types and constants of the ordered symbol table.
// ----------------------------------------------------------------------------
package ost_pkg;

	localparam int KEY_HEAD_W = 64;
	localparam int KEY_TAIL_W = 8;
	localparam int ADDR_W     = 32;
	localparam int OCC_W      = 5;
	localparam int MAX_RESULTS = 16;   // list emits at most this many entries
	localparam int Q_DEPTH    = 2;     // command queue between front and back

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LIST   = 2'd1,
		OP_DELETE = 2'd2,
		OP_SEARCH = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_INSERTED   = 3'd0,
		ST_DUPLICATE  = 3'd1,
		ST_FULL       = 3'd2,
		ST_DELETED    = 3'd3,
		ST_NOT_FOUND  = 3'd4,
		ST_FOUND      = 3'd5,
		ST_LIST_ENTRY = 3'd6,
		ST_LIST_EMPTY = 3'd7
	} status_t;

	// One table entry: canonical key plus address.
	typedef struct packed {
		logic [KEY_HEAD_W-1:0]   head;
		logic [KEY_TAIL_W-1:0]   tail;
		logic signed [ADDR_W-1:0] addr;
	} entry_t;

	// Command handed from front to back.
	typedef struct packed {
		op_t    op;
		entry_t ent;
	} cmd_t;

endpackage

// ===== hdl/ost_front.sv =====
// ----------------------------------------------------------------------------
// ost_front
// Input stage: takes a transfer, canonicalizes the key and registers the
// command for the queue.
// ----------------------------------------------------------------------------
module ost_front import ost_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               opcode,
	input  logic [KEY_HEAD_W-1:0]    key_head,
	input  logic [KEY_TAIL_W-1:0]    key_tail,
	input  logic signed [ADDR_W-1:0] new_address,
	output logic                     push_valid,
	input  logic                     push_ready,
	output cmd_t                     push_cmd
);

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_in;

	// Key ends at the first zero character; everything after it reads as zero.
	always_comb begin
		logic ended;
		ended = 1'b0;
		cmd_in.op = op_t'(opcode);
		cmd_in.ent.head = '0;
		for (int i = 7; i >= 0; i--) begin
			if (key_head[i*8 +: 8] == 8'd0)
				ended = 1'b1;
			if (!ended)
				cmd_in.ent.head[i*8 +: 8] = key_head[i*8 +: 8];
		end
		cmd_in.ent.tail = ended ? '0 : key_tail;
		cmd_in.ent.addr = new_address;
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd_in;
		end
	end

endmodule

// ===== hdl/ost_queue.sv =====
// ----------------------------------------------------------------------------
// ost_queue
// Short command FIFO decoupling the front stage from the table engine.
// ----------------------------------------------------------------------------
module ost_queue import ost_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int NW = $clog2(Q_DEPTH + 1);

	cmd_t          slot_q [Q_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] fill_q;
	logic          push;
	logic          pop;

	assign push_ready = (fill_q != NW'(Q_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== hdl/ost_back.sv =====
// ----------------------------------------------------------------------------
// ost_back
// Table engine: entry memory, scan / shift / list sequencer, result register.
// ----------------------------------------------------------------------------
module ost_back import ost_pkg::*; #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	output logic                     cmd_ready,
	input  cmd_t                     cmd,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [2:0]               status,
	output logic [KEY_HEAD_W-1:0]    entry_head,
	output logic [KEY_TAIL_W-1:0]    entry_tail,
	output logic signed [ADDR_W-1:0] entry_address,
	output logic [OCC_W-1:0]         occupancy,
	output logic                     last_of_run
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_SHIFT = 5'b00100,
		S_LIST  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	entry_t  mem [TABLE_DEPTH];
	entry_t  rdata_q;

	state_t  state_q;
	cmd_t    cmd_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;       // next entry to read
	logic          pend_q;      // rdata_q holds entry pend_idx_q
	logic [CW-1:0] pend_idx_q;
	status_t       done_st_q;

	logic          out_valid_q;
	status_t       out_st_q;
	entry_t        out_ent_q;
	logic [OCC_W-1:0] out_occ_q;
	logic          out_last_q;

	logic          slot_free;
	logic          hit;
	logic          miss;
	logic          list_last;
	logic          shift_done;
	logic          re;
	logic [AW-1:0] ra;
	logic          we;
	logic [AW-1:0] wa;
	entry_t        wd;

	assign slot_free  = !out_valid_q || out_ready;
	assign hit        = pend_q && (rdata_q.head == cmd_q.ent.head)
	                    && (rdata_q.tail == cmd_q.ent.tail);
	assign miss       = !pend_q && (idx_q == count_q);
	assign list_last  = (int'(pend_idx_q) + 1 == int'(count_q))
	                    || (int'(pend_idx_q) + 1 == MAX_RESULTS);
	assign shift_done = !pend_q && (idx_q >= count_q);
	assign cmd_ready  = (state_q == S_IDLE);

	// Memory port control
	always_comb begin
		re = 1'b0;
		ra = idx_q[AW-1:0];
		we = 1'b0;
		wa = count_q[AW-1:0];
		wd = cmd_q.ent;
		case (state_q)
			S_SCAN: begin
				if (!hit && idx_q < count_q)
					re = 1'b1;
				if (miss && cmd_q.op == OP_INSERT && count_q < CW'(TABLE_DEPTH))
					we = 1'b1;
			end
			S_SHIFT: begin
				if (pend_q) begin
					we = 1'b1;
					wa = AW'(pend_idx_q - 1'b1);
					wd = rdata_q;
				end
				if (idx_q < count_q)
					re = 1'b1;
			end
			S_LIST: begin
				if (!pend_q || (slot_free && !list_last))
					re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (re)
			rdata_q <= mem[ra];
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready)
			cmd_q <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			pend_idx_q  <= '0;
			done_st_q   <= ST_INSERTED;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (re) begin
				pend_q     <= 1'b1;
				pend_idx_q <= idx_q;
				idx_q      <= idx_q + 1'b1;
			end else if (state_q != S_LIST || slot_free) begin
				pend_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						idx_q  <= '0;
						pend_q <= 1'b0;
						if (cmd.op != OP_LIST) begin
							state_q <= S_SCAN;
						end else if (count_q == '0) begin
							done_st_q <= ST_LIST_EMPTY;
							state_q   <= S_DONE;
						end else begin
							state_q <= S_LIST;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						case (cmd_q.op)
							OP_INSERT: begin
								done_st_q <= ST_DUPLICATE;
								state_q   <= S_DONE;
							end
							OP_DELETE: begin
								idx_q   <= pend_idx_q + 1'b1;
								pend_q  <= 1'b0;
								state_q <= S_SHIFT;
							end
							default: begin
								done_st_q <= ST_FOUND;
								state_q   <= S_DONE;
							end
						endcase
					end else if (miss) begin
						state_q <= S_DONE;
						if (cmd_q.op == OP_INSERT) begin
							if (we) begin
								count_q   <= count_q + 1'b1;
								done_st_q <= ST_INSERTED;
							end else begin
								done_st_q <= ST_FULL;
							end
						end else begin
							done_st_q <= ST_NOT_FOUND;
						end
					end
				end
				S_SHIFT: begin
					if (shift_done) begin
						count_q   <= count_q - 1'b1;
						done_st_q <= ST_DELETED;
						state_q   <= S_DONE;
					end
				end
				S_LIST: begin
					if (pend_q && slot_free) begin
						out_valid_q <= 1'b1;
						if (list_last)
							state_q <= S_IDLE;
					end
				end
				S_DONE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (state_q == S_LIST && pend_q && slot_free) begin
			out_st_q   <= ST_LIST_ENTRY;
			out_ent_q  <= rdata_q;
			out_occ_q  <= OCC_W'(count_q);
			out_last_q <= list_last;
		end else if (state_q == S_DONE && slot_free) begin
			out_st_q   <= done_st_q;
			out_ent_q  <= '0;
			out_occ_q  <= OCC_W'(count_q);
			out_last_q <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_st_q;
	assign entry_head    = out_ent_q.head;
	assign entry_tail    = out_ent_q.tail;
	assign entry_address = out_ent_q.addr;
	assign occupancy     = out_occ_q;
	assign last_of_run   = out_last_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		((count_q == $past(count_q) + 1'b1) || (count_q + 1'b1 == $past(count_q))))
		else $error("entry count moved by more than one");

	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && pend_q) |-> (pend_idx_q < count_q && pend_idx_q != '0))
		else $error("compaction source outside occupied entries");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> (state_q != S_IDLE))
		else $error("command taken without starting work");
`endif

endmodule

// ===== hdl/ordered_symbol_table.sv =====
// ----------------------------------------------------------------------------
// ordered_symbol_table
// Fixed-depth symbol table with insertion-ordered entries.
// ----------------------------------------------------------------------------
// Keys of up to nine characters (zero padded; a key ends at its first zero
// character) map to a signed 32-bit address, kept in insertion order.
// Opcodes: insert, list, delete, search; each produces one result except
// list, which gives one per held entry (at most 16; one if empty) with
// last_of_run on the final one. A transfer is taken by a front stage into a
// two-deep command queue, so new commands are accepted while the engine is
// busy; a command passes the front register and the queue before the
// engine takes it. The engine walks the entry memory one entry per cycle
// through its single registered read port, pausing in a list while its
// output is not taken. Insert and search take the command, read one entry
// at a time, wait for the registered read, decide the miss and give the
// result, stopping early on a hit; delete scans up to the hit, then
// compaction moves each later entry down one place per cycle; list gives
// one result per cycle while the output is taken. Entries are not cleared
// at reset; only entries below the occupancy count are ever read.
// ----------------------------------------------------------------------------
module ordered_symbol_table import ost_pkg::*; #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               opcode,
	input  logic [KEY_HEAD_W-1:0]    key_head,
	input  logic [KEY_TAIL_W-1:0]    key_tail,
	input  logic signed [ADDR_W-1:0] new_address,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [2:0]               status,
	output logic [KEY_HEAD_W-1:0]    entry_head,
	output logic [KEY_TAIL_W-1:0]    entry_tail,
	output logic signed [ADDR_W-1:0] entry_address,
	output logic [OCC_W-1:0]         occupancy,
	output logic                     last_of_run
);

	// front -> queue
	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	// queue -> engine
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	ost_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.key_head    (key_head),
		.key_tail    (key_tail),
		.new_address (new_address),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_cmd    (push_cmd)
	);

	ost_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	// Engine owns the table memory and the result register.
	ost_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (pop_valid),
		.cmd_ready     (pop_ready),
		.cmd           (pop_cmd),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.entry_head    (entry_head),
		.entry_tail    (entry_tail),
		.entry_address (entry_address),
		.occupancy     (occupancy),
		.last_of_run   (last_of_run)
	);

endmodule

// ===== sim/tb_ordered_symbol_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_symbol_table
// Self-checking testbench for the ordered symbol table.
// ----------------------------------------------------------------------------
// A shadow table predicts every result from the accepted input transfers. A
// checker pops one prediction per output transfer and compares all fields.
// Directed tests cover the empty table, key forms, ordered delete and the
// full table. Random phases follow, mostly with bursty input and a stalling
// output, plus one long output hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_ordered_symbol_table;
	import ost_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam int POOL_SIZE   = 20;
	// Worst case is a 16-entry list under stalls, over a few hundred items.
	// The limit sits far above that.
	localparam int unsigned CYCLE_LIMIT = 500000;
	// Cycles of quiet after the last result.
	localparam int SETTLE_CYCLES = 48;

	typedef enum logic {
		RX_ALWAYS,
		RX_PATTERN
	} rx_mode_t;

	// One predicted output transfer.
	typedef struct {
		status_t                  status;
		logic [KEY_HEAD_W-1:0]    head;
		logic [KEY_TAIL_W-1:0]    tail;
		logic signed [ADDR_W-1:0] addr;
		logic [OCC_W-1:0]         occ;
		logic                     is_last;
	} table_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [1:0]               opcode;
	logic [KEY_HEAD_W-1:0]    key_head;
	logic [KEY_TAIL_W-1:0]    key_tail;
	logic signed [ADDR_W-1:0] new_address;
	logic                     out_valid;
	logic                     out_ready;
	logic [2:0]               status;
	logic [KEY_HEAD_W-1:0]    entry_head;
	logic [KEY_TAIL_W-1:0]    entry_tail;
	logic signed [ADDR_W-1:0] entry_address;
	logic [OCC_W-1:0]         occupancy;
	logic                     last_of_run;

	// Shadow copy of the table contents, in insertion order.
	logic [71:0]              shadow_key [TABLE_DEPTH];
	logic signed [ADDR_W-1:0] shadow_addr [TABLE_DEPTH];
	int                       shadow_count = 0;

	table_result_t pending_results[$];
	logic [71:0]   key_pool [POOL_SIZE];

	rx_mode_t    rx_mode = RX_ALWAYS;
	int          hold_left = 0;     // output hold-off, counted by the receiver
	int          mismatches = 0;
	int          transfers_in = 0;
	int          results_checked = 0;
	int          status_count [8];
	int unsigned cycle_count = 0;

	ordered_symbol_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.key_head     (key_head),
		.key_tail     (key_tail),
		.new_address  (new_address),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.entry_head   (entry_head),
		.entry_tail   (entry_tail),
		.entry_address(entry_address),
		.occupancy    (occupancy),
		.last_of_run  (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// A key ends at its first zero character; everything after it reads as zero.
	// Keys are held as 72 bits, character 1 in the top byte.
	function automatic logic [71:0] canon_key(input logic [71:0] k);
		logic [71:0] kept;
		logic        ended;
		kept  = '0;
		ended = 1'b0;
		for (int j = 0; j < 9; j++) begin
			if (k[71-8*j -: 8] == 8'h00)
				ended = 1'b1;
			if (!ended)
				kept[71-8*j -: 8] = k[71-8*j -: 8];
		end
		return kept;
	endfunction

	function automatic int find_shadow(input logic [71:0] ck);
		for (int i = 0; i < shadow_count; i++)
			if (shadow_key[i] == ck)
				return i;
		return -1;
	endfunction

	task automatic push_result(input status_t st, input logic [71:0] k,
			input logic signed [ADDR_W-1:0] a, input logic is_last);
		table_result_t r;
		r.status  = st;
		r.head    = k[71:8];
		r.tail    = k[7:0];
		r.addr    = a;
		r.occ     = OCC_W'(shadow_count);
		r.is_last = is_last;
		pending_results.push_back(r);
	endtask

	// Apply one accepted command to the shadow table and queue its results.
	task automatic predict_table_op(input op_t op, input logic [71:0] raw_key,
			input logic signed [ADDR_W-1:0] a);
		logic [71:0] ck;
		int          pos;
		int          n;
		ck  = canon_key(raw_key);
		pos = find_shadow(ck);
		case (op)
			OP_INSERT: begin
				if (pos >= 0) begin
					push_result(ST_DUPLICATE, '0, '0, 1'b1);
				end else if (shadow_count >= TABLE_DEPTH) begin
					push_result(ST_FULL, '0, '0, 1'b1);
				end else begin
					shadow_key[shadow_count]  = ck;
					shadow_addr[shadow_count] = a;
					shadow_count++;
					push_result(ST_INSERTED, '0, '0, 1'b1);
				end
			end
			OP_LIST: begin
				if (shadow_count == 0) begin
					push_result(ST_LIST_EMPTY, '0, '0, 1'b1);
				end else begin
					n = (shadow_count < MAX_RESULTS) ? shadow_count : MAX_RESULTS;
					for (int i = 0; i < n; i++)
						push_result(ST_LIST_ENTRY, shadow_key[i], shadow_addr[i], i + 1 == n);
				end
			end
			OP_DELETE: begin
				if (pos < 0) begin
					push_result(ST_NOT_FOUND, '0, '0, 1'b1);
				end else begin
					// close the gap, order kept
					for (int i = pos; i + 1 < shadow_count; i++) begin
						shadow_key[i]  = shadow_key[i+1];
						shadow_addr[i] = shadow_addr[i+1];
					end
					shadow_count--;
					push_result(ST_DELETED, '0, '0, 1'b1);
				end
			end
			default: begin
				push_result(pos >= 0 ? ST_FOUND : ST_NOT_FOUND, '0, '0, 1'b1);
			end
		endcase
	endtask

	// ------------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------------

	// Offer one command and hold it until the transfer happens. Called at a
	// rising edge; returns at the edge of the transfer.
	task automatic send_cmd(input op_t op, input logic [71:0] k,
			input logic signed [ADDR_W-1:0] a);
		in_valid    <= 1'b1;
		opcode      <= op;
		key_head    <= k[71:8];
		key_tail    <= k[7:0];
		new_address <= a;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		predict_table_op(op, k, a);
		transfers_in++;
	endtask

	task automatic idle_sender(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Sender pause: nothing offered until every predicted result is back, then
	// SETTLE_CYCLES of quiet.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// After the key's end, sometimes fill the dead characters with junk; the
	// block must treat them as zero.
	function automatic logic [71:0] garble_after_end(input logic [71:0] k);
		logic [71:0] g;
		logic        ended;
		g     = k;
		ended = 1'b0;
		for (int j = 0; j < 9; j++) begin
			if (ended && $urandom_range(0, 1))
				g[71-8*j -: 8] = 8'($urandom);
			if (k[71-8*j -: 8] == 8'h00)
				ended = 1'b1;
		end
		return g;
	endfunction

	// Keys of every length 0..9, some stored already junked past their end.
	task automatic build_key_pool();
		int len;
		for (int p = 0; p < POOL_SIZE; p++) begin
			len         = (p < 10) ? p : $urandom_range(0, 9);
			key_pool[p] = '0;
			for (int j = 0; j < len; j++)
				key_pool[p][71-8*j -: 8] = 8'($urandom_range(1, 255));
			if (p % 3 == 0)
				key_pool[p] = garble_after_end(key_pool[p]);
		end
	endtask

	function automatic logic [71:0] random_key();
		return {$urandom, $urandom, 8'($urandom)};
	endfunction

	function automatic logic signed [ADDR_W-1:0] rand_address();
		case ($urandom_range(0, 9))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic op_t pick_op(input int wi, input int wl, input int wd, input int ws);
		int r;
		r = $urandom_range(0, wi + wl + wd + ws - 1);
		if (r < wi)
			return OP_INSERT;
		if (r < wi + wl)
			return OP_LIST;
		if (r < wi + wl + wd)
			return OP_DELETE;
		return OP_SEARCH;
	endfunction

	// Lookups favor held keys so that hits and deletes are common.
	function automatic logic [71:0] pick_key(input op_t op);
		int r;
		r = $urandom_range(0, 9);
		if (op != OP_INSERT && shadow_count > 0 && r < 5)
			return garble_after_end(shadow_key[$urandom_range(0, shadow_count - 1)]);
		if (r < 8)
			return garble_after_end(key_pool[$urandom_range(0, POOL_SIZE - 1)]);
		return random_key();
	endfunction

	task automatic run_random_phase(input int n, input int wi, input int wl,
			input int wd, input int ws, input bit gappy);
		int          burst_left;
		op_t         op;
		logic [71:0] k;
		burst_left = $urandom_range(1, 8);
		for (int i = 0; i < n; i++) begin
			op = pick_op(wi, wl, wd, ws);
			k  = pick_key(op);
			send_cmd(op, k, rand_address());
			if (gappy) begin
				burst_left--;
				if (burst_left == 0) begin
					idle_sender($urandom_range(1, 12));
					burst_left = $urandom_range(1, 10);
				end
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	task automatic test_empty_table();
		send_cmd(OP_LIST, '0, '0);
		send_cmd(OP_SEARCH, '0, 32'sd5);
		send_cmd(OP_DELETE, {64'h4142_4300_0000_0000, 8'h00}, '0);
		drain_results();
	endtask

	task automatic test_key_forms();
		// all-zero key is legal; extremes of the address
		send_cmd(OP_INSERT, '0, 32'sh8000_0000);
		send_cmd(OP_INSERT, {64'hffff_ffff_ffff_ffff, 8'hff}, 32'sh7fff_ffff);
		// embedded terminator: stored as the one-character key "A"
		send_cmd(OP_INSERT, {64'h4100_4243_4445_4647, 8'h55}, 32'sh1234_5678);
		// same key with other junk after its end, and the zero key with junk
		send_cmd(OP_INSERT, {64'h4100_9999_0000_0001, 8'h01}, 32'sh0);
		send_cmd(OP_INSERT, {64'h0000_0000_0000_0000, 8'h07}, 32'sh1);
		send_cmd(OP_SEARCH, {64'h4100_0000_0000_0000, 8'h00}, '0);
		send_cmd(OP_SEARCH, {64'hffff_ffff_ffff_ffff, 8'hfe}, '0);
		send_cmd(OP_LIST, '0, '0);
		drain_results();
	endtask

	task automatic test_ordered_delete();
		// drop the middle entry, then the list must keep the other two in order
		send_cmd(OP_DELETE, {64'hffff_ffff_ffff_ffff, 8'hff}, '0);
		send_cmd(OP_LIST, '0, '0);
		drain_results();
	endtask

	task automatic test_full_table();
		logic [71:0] k;
		int          i;
		i = 0;
		while (shadow_count < TABLE_DEPTH) begin
			k = {8'h54, 8'(8'h41 + i), 48'($urandom) | 48'h0101_0101_0101, 8'($urandom)};
			send_cmd(OP_INSERT, k, rand_address());
			i++;
		end
		send_cmd(OP_INSERT, {64'h4e45_5700_0000_0000, 8'h00}, 32'sh42);
		// duplicate check comes before the full check
		send_cmd(OP_INSERT, shadow_key[5], 32'sh43);
		send_cmd(OP_LIST, '0, '0);
		send_cmd(OP_DELETE, shadow_key[0], '0);
		k = shadow_key[shadow_count - 1];
		send_cmd(OP_DELETE, k, '0);
		send_cmd(OP_SEARCH, k, '0);
		drain_results();
	endtask

	task automatic test_mixed_traffic();
		rx_mode <= RX_PATTERN;
		run_random_phase(60, 3, 1, 2, 2, 1'b1);
		drain_results();
	endtask

	// Fill up back-to-back, output always ready; then empty out with gaps and stalls.
	task automatic test_fill_and_empty();
		rx_mode <= RX_ALWAYS;
		run_random_phase(55, 8, 1, 1, 1, 1'b0);
		drain_results();
		rx_mode <= RX_PATTERN;
		run_random_phase(55, 1, 2, 6, 2, 1'b1);
		drain_results();
	endtask

	// Output held off for a long stretch while input keeps coming, so the
	// command queue fills and the block stops taking transfers.
	task automatic test_output_backpressure();
		hold_left <= 300;
		rx_mode   <= RX_PATTERN;
		for (int i = 0; i < 20; i++)
			send_cmd((i % 5 == 2) ? OP_LIST : pick_op(2, 0, 1, 2),
				pick_key(OP_SEARCH), rand_address());
		drain_results();
	endtask

	task automatic test_list_heavy();
		rx_mode <= RX_PATTERN;
		run_random_phase(40, 3, 3, 1, 1, 1'b1);
		drain_results();
	endtask

	// ------------------------------------------------------------------------
	// Output side
	// ------------------------------------------------------------------------

	// Receiver: always ready, ready/stall runs of random length, or a counted hold-off.
	initial begin : receiver
		int   run_left;
		logic run_ready;
		run_left  = 0;
		run_ready = 1'b1;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (rx_mode == RX_ALWAYS) begin
				out_ready <= 1'b1;
			end else begin
				if (run_left == 0) begin
					run_ready = !run_ready;
					run_left  = run_ready ? $urandom_range(1, 12) : $urandom_range(1, 6);
				end
				run_left--;
				out_ready <= run_ready;
			end
		end
	end

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Sampled at the edge, so values are those of the transfer itself.
	always @(posedge clk) begin : result_checker
		table_result_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			results_checked++;
			status_count[status]++;
			if (pending_results.size() == 0) begin
				$error("unexpected result transfer, status %0d", status);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 64'(want.status), 64'(status));
				check_field("entry_head", want.head, entry_head);
				check_field("entry_tail", 64'(want.tail), 64'(entry_tail));
				check_field("entry_address", 64'(unsigned'(want.addr)),
					64'(unsigned'(entry_address)));
				check_field("occupancy", 64'(want.occ), 64'(occupancy));
				check_field("last_of_run", 64'(want.is_last), 64'(last_of_run));
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding",
			cycle_count, pending_results.size());
		$display("tb_ordered_symbol_table: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		for (int s = 0; s < 8; s++)
			status_count[s] = 0;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		opcode      <= OP_INSERT;
		key_head    <= '0;
		key_tail    <= '0;
		new_address <= '0;
		build_key_pool();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_key_forms();
		test_ordered_delete();
		test_full_table();
		test_mixed_traffic();
		test_fill_and_empty();
		test_output_backpressure();
		test_list_heavy();
		drain_results();

		$display("covered %0d input transfers, %0d result transfers checked",
			transfers_in, results_checked);
		$display("inserted %0d, duplicate %0d, full %0d, deleted %0d, miss %0d, hit %0d, listed %0d",
			status_count[ST_INSERTED], status_count[ST_DUPLICATE], status_count[ST_FULL],
			status_count[ST_DELETED], status_count[ST_NOT_FOUND], status_count[ST_FOUND],
			status_count[ST_LIST_ENTRY]);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb_ordered_symbol_table: PASS");
		else
			$display("tb_ordered_symbol_table: FAIL");
		$finish;
	end

endmodule
